// File: design/ts_pes_payload_extractor_unit_defines.svh
// Assertion macros shared by the extractor modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TS_PES_PAYLOAD_EXTRACTOR_UNIT_DEFINES_SVH
`define TS_PES_PAYLOAD_EXTRACTOR_UNIT_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define TSPE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle
`define TSPE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define TSPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tspe_pkg.sv
// Shared types and constants for the transport stream PES payload extractor.
// Depends on nothing; used by the interfaces and all modules.
package tspe_pkg;

    localparam int DATA_W         = 8;
    localparam int RING_SIZE_W    = 21;
    localparam int WRITE_OFFSET_W = 20;
    localparam int STATUS_W       = 2;
    localparam int TS_W           = 33;
    localparam int PACKET_BYTES   = 188;
    localparam int RING_ADDR_BITS = 20;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [RING_SIZE_W-1:0] RING_SIZE_RESET = 21'h100000;
    localparam logic [TS_W-1:0]        TS_ALL_ONES     = 33'h1_FFFF_FFFF;

    // Result kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Packet status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SYNC  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_START = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FLAGS = 2'd3;

    // Work left for the back end by one item
    typedef struct packed {
        logic                wr_en;
        logic [DATA_W-1:0]   wr_byte;
        logic                st_en;
        logic [STATUS_W-1:0] status;
        logic [TS_W-1:0]     ts;
        logic                ts_upd;
    } action_t;

endpackage

// File: design/tspe_if.sv
// Valid/ready channel interfaces: transport bytes in, ring writes and status out.
// Depends on tspe_pkg.
interface tspe_in_if;
    logic                        valid;
    logic                        ready;
    logic [tspe_pkg::DATA_W-1:0] data_byte;
    logic                        packet_first;

    modport source (output valid, output data_byte, output packet_first, input ready);
    modport sink (input valid, input data_byte, input packet_first, output ready);
endinterface

interface tspe_out_if;
    logic                                valid;
    logic                                ready;
    logic                                result_kind;
    logic [tspe_pkg::WRITE_OFFSET_W-1:0] write_offset;
    logic [tspe_pkg::DATA_W-1:0]         payload_byte;
    logic [tspe_pkg::STATUS_W-1:0]       status;
    logic [tspe_pkg::TS_W-1:0]           timestamp;
    logic                                timestamp_updated;

    modport source (output valid, output result_kind, output write_offset,
                    output payload_byte, output status, output timestamp,
                    output timestamp_updated, input ready);
    modport sink (input valid, input result_kind, input write_offset,
                  input payload_byte, input status, input timestamp,
                  input timestamp_updated, output ready);
endinterface

// File: design/tspe_front.sv
// Front end: parses transport packet and PES headers one byte per cycle when q_ready.
// Depends on tspe_pkg; pushes at most one action per item into the action queue.
`include "ts_pes_payload_extractor_unit_defines.svh"

module tspe_front #(
    parameter int PACKET_BYTES = tspe_pkg::PACKET_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tspe_pkg::DATA_W-1:0]   data_byte,
    input  logic                          packet_first,
    output logic                          push,
    output tspe_pkg::action_t             push_data,
    input  logic                          q_ready
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_ALEN,
        PH_ASKIP,
        PH_PES,
        PH_PAY,
        PH_DROP
    } phase_t;

    localparam logic [7:0] SYNC_BYTE  = 8'h47;
    localparam logic [7:0] LAST_INDEX = 8'(PACKET_BYTES - 1);

    phase_t                        phase_reg, phase_next;
    logic [7:0]                    byte_index_reg, byte_index_next;
    logic [7:0]                    skip_reg, skip_next;
    logic [1:0]                    flags_reg, flags_next;
    logic [tspe_pkg::TS_W-1:0]     pts_reg, pts_next;
    logic [tspe_pkg::STATUS_W-1:0] err_reg, err_next;
    logic                          pay_start_reg, pay_start_next;
    logic [7:0]                    pes_pos_reg, pes_pos_next;
    logic [7:0]                    hdr_len_reg, hdr_len_next;
    logic                          ts_valid_reg, ts_valid_next;

    logic                          accept;
    logic                          active;
    logic [7:0]                    byte_index_cur;
    logic [8:0]                    pay_from;
    tspe_pkg::action_t             act;

    // Stream ids whose PES carries the optional header
    function automatic logic has_pes_header(input logic [7:0] id);
        logic res;
        res = 1'b1;
        if (id < 8'hBC)
        begin
            res = 1'b0;
        end
        else if (id >= 8'hF4 && id <= 8'hFE)
        begin
            res = 1'b0;
        end
        else if (id inside {8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hFF})
        begin
            res = 1'b0;
        end
        return res;
    endfunction

    assign in_ready  = q_ready;
    assign accept    = in_valid && q_ready;
    assign push      = accept && (act.wr_en || act.st_en);
    assign push_data = act;
    assign pay_from  = 9'd9 + {1'b0, hdr_len_reg};

    // Parse one byte and work out the action it leaves behind
    always_comb
    begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        skip_next       = skip_reg;
        flags_next      = flags_reg;
        pts_next        = pts_reg;
        err_next        = err_reg;
        pay_start_next  = pay_start_reg;
        pes_pos_next    = pes_pos_reg;
        hdr_len_next    = hdr_len_reg;
        ts_valid_next   = ts_valid_reg;
        act             = '0;
        act.wr_byte     = data_byte;
        active          = 1'b1;
        byte_index_cur  = byte_index_reg;

        if (packet_first)
        begin
            byte_index_cur = 8'd0;
            err_next       = tspe_pkg::ST_OK;
            pay_start_next = 1'b0;
            flags_next     = 2'd0;
            pts_next       = '0;
            skip_next      = 8'd0;
            pes_pos_next   = 8'd0;
            hdr_len_next   = 8'd0;
            ts_valid_next  = 1'b0;
            if (data_byte != SYNC_BYTE)
            begin
                err_next   = tspe_pkg::ST_BAD_SYNC;
                phase_next = PH_DROP;
            end
            else
            begin
                phase_next = PH_HDR;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    active = 1'b0;
                end
                PH_HDR:
                begin
                    if (byte_index_reg == 8'd1)
                    begin
                        pay_start_next = data_byte[6];
                    end
                    else if (byte_index_reg == 8'd3)
                    begin
                        case (data_byte[5:4])
                            2'b11:   phase_next = PH_ALEN;
                            2'b10:   phase_next = PH_DROP;
                            default:
                            begin
                                phase_next   = pay_start_reg ? PH_PES : PH_PAY;
                                pes_pos_next = 8'd0;
                            end
                        endcase
                    end
                end
                PH_ALEN:
                begin
                    skip_next = data_byte;
                    if (data_byte == 8'd0)
                    begin
                        phase_next   = pay_start_reg ? PH_PES : PH_PAY;
                        pes_pos_next = 8'd0;
                    end
                    else
                    begin
                        phase_next = PH_ASKIP;
                    end
                end
                PH_ASKIP:
                begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_reg == 8'd1)
                    begin
                        phase_next   = pay_start_reg ? PH_PES : PH_PAY;
                        pes_pos_next = 8'd0;
                    end
                end
                PH_PES:
                begin
                    // Start code, stream id, header flags and header length
                    if (pes_pos_reg <= 8'd1)
                    begin
                        if (data_byte != 8'd0)
                        begin
                            err_next   = tspe_pkg::ST_BAD_START;
                            phase_next = PH_DROP;
                        end
                    end
                    else if (pes_pos_reg == 8'd2)
                    begin
                        if (data_byte != 8'd1)
                        begin
                            err_next   = tspe_pkg::ST_BAD_START;
                            phase_next = PH_DROP;
                        end
                    end
                    else if (pes_pos_reg == 8'd3)
                    begin
                        if (has_pes_header(data_byte))
                        begin
                            ts_valid_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DROP;
                        end
                    end
                    else if (pes_pos_reg == 8'd7)
                    begin
                        flags_next = data_byte[7:6];
                        if (data_byte[5:0] != 6'd0)
                        begin
                            err_next = tspe_pkg::ST_BAD_FLAGS;
                        end
                    end
                    else if (pes_pos_reg == 8'd8)
                    begin
                        hdr_len_next = data_byte;
                    end

                    // Gather the PTS bits
                    case (pes_pos_reg)
                        8'd9:    pts_next[32:30] = pts_reg[32:30] | data_byte[3:1];
                        8'd10:   pts_next[29:22] = pts_reg[29:22] | data_byte;
                        8'd11:   pts_next[21:15] = pts_reg[21:15] | data_byte[7:1];
                        8'd12:   pts_next[14:7]  = pts_reg[14:7] | data_byte;
                        8'd13:   pts_next[6:0]   = pts_reg[6:0] | data_byte[7:1];
                        default: pts_next        = pts_reg;
                    endcase

                    if (pes_pos_reg >= 8'd9 && {1'b0, pes_pos_reg} >= pay_from &&
                        err_reg == tspe_pkg::ST_OK)
                    begin
                        act.wr_en = 1'b1;
                    end
                    if (pes_pos_reg != 8'hFF)
                    begin
                        pes_pos_next = pes_pos_reg + 8'd1;
                    end
                end
                PH_PAY:
                begin
                    act.wr_en = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // Close the packet on its last byte
        if (active)
        begin
            if (byte_index_cur >= LAST_INDEX)
            begin
                if (pay_start_next && err_next == tspe_pkg::ST_OK &&
                    (phase_next == PH_ALEN || phase_next == PH_ASKIP ||
                     (phase_next == PH_PES && pes_pos_next < 8'd4)))
                begin
                    err_next = tspe_pkg::ST_BAD_START;
                end
                act.st_en  = 1'b1;
                act.status = err_next;
                act.ts_upd = ts_valid_next;
                if (ts_valid_next)
                begin
                    if (flags_next[1])
                    begin
                        act.ts = pts_next;
                    end
                    else if (flags_next == 2'd0)
                    begin
                        act.ts = tspe_pkg::TS_ALL_ONES;
                    end
                end
                phase_next      = PH_IDLE;
                byte_index_next = 8'd0;
            end
            else
            begin
                byte_index_next = byte_index_cur + 8'd1;
            end
        end
    end

    // Hold parse state, advance on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_index_reg <= 8'd0;
            skip_reg       <= 8'd0;
            flags_reg      <= 2'd0;
            pts_reg        <= '0;
            err_reg        <= tspe_pkg::ST_OK;
            pay_start_reg  <= 1'b0;
            pes_pos_reg    <= 8'd0;
            hdr_len_reg    <= 8'd0;
            ts_valid_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            skip_reg       <= skip_next;
            flags_reg      <= flags_next;
            pts_reg        <= pts_next;
            err_reg        <= err_next;
            pay_start_reg  <= pay_start_next;
            pes_pos_reg    <= pes_pos_next;
            hdr_len_reg    <= hdr_len_next;
            ts_valid_reg   <= ts_valid_next;
        end
    end

    `TSPE_ASSERT_IMPLY(a_idle_quiet, clk, rst_n, accept && phase_reg == PH_IDLE && !packet_first, !push, "idle byte produced an action")
    `TSPE_ASSERT_IMPLY(a_push_room, clk, rst_n, push, q_ready, "push into a full queue")

endmodule

// File: design/tspe_queue.sv
// Short action queue that decouples the parser from the result stage.
// Depends on tspe_pkg for the action type.
`include "ts_pes_payload_extractor_unit_defines.svh"

module tspe_queue #(
    parameter int DEPTH = tspe_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tspe_pkg::action_t push_data,
    output logic              push_ready,
    input  logic              pop,
    output tspe_pkg::action_t head,
    output logic              head_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tspe_pkg::action_t entries_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    assign push_ready = (cnt_reg != CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed action
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    `TSPE_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CW'(DEPTH), "queue count past depth")
    `TSPE_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, head_valid, "pop from an empty queue")
    `TSPE_ASSERT_NEXT(a_cnt_grow, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "count did not grow on push")

endmodule

// File: design/tspe_back.sv
// Back end: places payload bytes in the ring and registers each result.
// Depends on tspe_pkg; drains the action queue, holds ring_size and ring offset.
`include "ts_pes_payload_extractor_unit_defines.svh"

module tspe_back #(
    parameter int RING_ADDR_BITS = tspe_pkg::RING_ADDR_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [tspe_pkg::RING_SIZE_W-1:0]    cfg_wr_data,
    input  tspe_pkg::action_t                   head,
    input  logic                                head_valid,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                result_kind,
    output logic [tspe_pkg::WRITE_OFFSET_W-1:0] write_offset,
    output logic [tspe_pkg::DATA_W-1:0]         payload_byte,
    output logic [tspe_pkg::STATUS_W-1:0]       status,
    output logic [tspe_pkg::TS_W-1:0]           timestamp,
    output logic                                timestamp_updated
);

    localparam int RW = RING_ADDR_BITS;
    localparam int SW = (RW + 1 > tspe_pkg::RING_SIZE_W) ? RW + 1 : tspe_pkg::RING_SIZE_W;
    localparam int OW = tspe_pkg::WRITE_OFFSET_W;

    logic [tspe_pkg::RING_SIZE_W-1:0] ring_size_reg;
    logic [RW-1:0]                    ring_off_reg, ring_off_next;
    logic                             wr_done_reg, wr_done_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             load;

    logic                             kind_reg, kind_next;
    logic [OW-1:0]                    off_reg, off_next;
    logic [tspe_pkg::DATA_W-1:0]      byte_reg, byte_next;
    logic [tspe_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [tspe_pkg::TS_W-1:0]        ts_reg, ts_next;
    logic                             upd_reg, upd_next;

    logic [SW-1:0]                    size_req;
    logic [SW-1:0]                    size_cap;
    logic [SW-1:0]                    size_eff;
    logic [RW-1:0]                    off_cur;
    logic [SW-1:0]                    off_inc;

    // Effective ring size and wrapped offsets
    always_comb
    begin
        size_req = SW'(ring_size_reg);
        size_cap = SW'(1) << RW;
        size_eff = (size_req == '0 || size_req > size_cap) ? size_cap : size_req;
        off_cur  = (SW'(ring_off_reg) >= size_eff) ? '0 : ring_off_reg;
        off_inc  = SW'(off_cur) + SW'(1);
    end

    assign load = !out_valid_reg || out_ready;

    // Emit the write first, then the status of the same item
    always_comb
    begin
        ring_off_next  = ring_off_reg;
        wr_done_next   = wr_done_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;
        kind_next      = kind_reg;
        off_next       = off_reg;
        byte_next      = byte_reg;
        status_next    = status_reg;
        ts_next        = ts_reg;
        upd_next       = upd_reg;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                if (head.wr_en && !wr_done_reg)
                begin
                    kind_next     = tspe_pkg::KIND_WRITE;
                    off_next      = OW'(off_cur);
                    byte_next     = head.wr_byte;
                    status_next   = tspe_pkg::ST_OK;
                    ts_next       = '0;
                    upd_next      = 1'b0;
                    ring_off_next = (off_inc >= size_eff) ? '0 : off_inc[RW-1:0];
                    if (head.st_en)
                    begin
                        wr_done_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    kind_next    = tspe_pkg::KIND_STATUS;
                    off_next     = '0;
                    byte_next    = '0;
                    status_next  = head.status;
                    ts_next      = head.ts;
                    upd_next     = head.ts_upd;
                    wr_done_next = 1'b0;
                    pop          = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= tspe_pkg::RING_SIZE_RESET;
            ring_off_reg  <= '0;
            wr_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ring_size_reg <= cfg_wr_data;
            end
            ring_off_reg  <= ring_off_next;
            wr_done_reg   <= wr_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        off_reg    <= off_next;
        byte_reg   <= byte_next;
        status_reg <= status_next;
        ts_reg     <= ts_next;
        upd_reg    <= upd_next;
    end

    assign out_valid         = out_valid_reg;
    assign result_kind       = kind_reg;
    assign write_offset      = off_reg;
    assign payload_byte      = byte_reg;
    assign status            = status_reg;
    assign timestamp         = ts_reg;
    assign timestamp_updated = upd_reg;

    `TSPE_ASSERT_IMPLY(a_split_head, clk, rst_n, wr_done_reg, head_valid && head.st_en, "split item lost its head")
    `TSPE_ASSERT_IMPLY(a_write_clean, clk, rst_n, out_valid_reg && kind_reg == tspe_pkg::KIND_WRITE, status_reg == tspe_pkg::ST_OK && !upd_reg, "payload write carries status")

endmodule

// File: design/ts_pes_payload_extractor_unit.sv
// The action queue takes a byte's action at the accepting edge, and the output register
// then loads it from the queue head.
// Throughput: one byte per cycle while the queue has room; the last byte of a packet that
// also carries payload gives two results, a write and then its status, which leave the
// output register in turn; the four-entry action queue absorbs the extra one until full.
// Reset: rst_n asynchronous, active low; parser idle, ring offset 0, ring_size 1048576.
module ts_pes_payload_extractor_unit #(
    parameter int PACKET_BYTES   = tspe_pkg::PACKET_BYTES,
    parameter int RING_ADDR_BITS = tspe_pkg::RING_ADDR_BITS,
    parameter int QUEUE_DEPTH    = tspe_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tspe_in_if.sink                          stream,
    tspe_out_if.source                       result,
    input  logic                             cfg_wr_en,
    input  logic [tspe_pkg::RING_SIZE_W-1:0] cfg_wr_data
);

    logic              push;
    logic              push_ready;
    logic              pop;
    logic              head_valid;
    tspe_pkg::action_t push_data;
    tspe_pkg::action_t head;

    // Parse bytes into actions
    tspe_front #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (stream.valid),
        .in_ready     (stream.ready),
        .data_byte    (stream.data_byte),
        .packet_first (stream.packet_first),
        .push         (push),
        .push_data    (push_data),
        .q_ready      (push_ready)
    );

    // Buffer actions between the two sides
    tspe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // Turn actions into ring writes and status results
    tspe_back #(
        .RING_ADDR_BITS(RING_ADDR_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .head              (head),
        .head_valid        (head_valid),
        .pop               (pop),
        .out_valid         (result.valid),
        .out_ready         (result.ready),
        .result_kind       (result.result_kind),
        .write_offset      (result.write_offset),
        .payload_byte      (result.payload_byte),
        .status            (result.status),
        .timestamp         (result.timestamp),
        .timestamp_updated (result.timestamp_updated)
    );

endmodule
